// ===== design/rdz_pkg.sv =====
// ----------------------------------------------------------------------------
// rdz_pkg
// shared types, register codes and helpers of the radial dead zone rescaler
// ----------------------------------------------------------------------------
package rdz_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_IDX_BITS    = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOWER = 2'd0,
        CFG_UPPER = 2'd1,
        CFG_VALUE = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ZONE_DEAD = 2'd0,
        ZONE_RAMP = 2'd1,
        ZONE_SAT  = 2'd2,
        ZONE_BAD  = 2'd3
    } t_zone;

    localparam logic [15:0] Q15_LOWER = 16'd3277;
    localparam logic [15:0] Q15_UPPER = 16'd29491;
    localparam logic [15:0] Q15_VALUE = 16'd32767;

    // q1.15 constant moved to an n-bit sample format
    function automatic logic [63:0] rdz_from_q15(input logic [15:0] v, input int n);
        logic [63:0] w;
        w = {48'd0, v};
        if (n >= 16) begin
            w = w << (n - 16);
        end else begin
            w = w >> (16 - n);
        end
        return w & ((64'd1 << (n - 1)) - 64'd1);
    endfunction

    // edges from accepted start to output strobe
    function automatic int rdz_latency(input int n);
        return 3 * n + 4;
    endfunction

endpackage

// ===== design/rdz_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rdz_sqrt_cell
// one restoring square root step, resolves root bit K and passes on
// ----------------------------------------------------------------------------
module rdz_sqrt_cell import rdz_pkg::*; #(
    parameter int W  = 33,
    parameter int RN = 16,
    parameter int K  = 0,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_rem,
    input  logic [RN-1:0] i_root,
    input  logic [PW-1:0] i_pass,
    output logic          o_valid,
    output logic [W-1:0]  o_rem,
    output logic [RN-1:0] o_root,
    output logic [PW-1:0] o_pass
);

    logic [W-1:0]  trial;
    logic          ge;
    logic [W-1:0]  n_rem;
    logic [RN-1:0] n_root;
    logic          r_valid;
    logic [W-1:0]  r_rem;
    logic [RN-1:0] r_root;
    logic [PW-1:0] r_pass;

    always_comb begin
        trial  = (W'(i_root) << (K + 1)) + (W'(1) << (2 * K));
        ge     = (i_rem >= trial);
        n_rem  = ge ? (i_rem - trial) : i_rem;
        n_root = i_root;
        n_root[K] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_pass <= i_pass;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_pass  = r_pass;

endmodule

// ===== design/rdz_div_cell.sv =====
// ----------------------------------------------------------------------------
// rdz_div_cell
// one restoring division step, resolves quotient bit K and passes on
// ----------------------------------------------------------------------------
module rdz_div_cell import rdz_pkg::*; #(
    parameter int W  = 33,
    parameter int QB = 15,
    parameter int K  = 0,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_rem,
    input  logic [W-1:0]  i_den,
    input  logic [QB-1:0] i_quo,
    input  logic [PW-1:0] i_pass,
    output logic          o_valid,
    output logic [W-1:0]  o_rem,
    output logic [W-1:0]  o_den,
    output logic [QB-1:0] o_quo,
    output logic [PW-1:0] o_pass
);

    logic [W-1:0]  trial;
    logic          ge;
    logic [W-1:0]  n_rem;
    logic [QB-1:0] n_quo;
    logic          r_valid;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [QB-1:0] r_quo;
    logic [PW-1:0] r_pass;

    always_comb begin
        trial = i_den << K;
        ge    = (i_rem >= trial);
        n_rem = ge ? (i_rem - trial) : i_rem;
        n_quo = i_quo;
        n_quo[K] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= i_den;
        r_quo  <= n_quo;
        r_pass <= i_pass;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_pass  = r_pass;

endmodule

// ===== design/radial_dead_zone_rescale_top.sv =====
// ----------------------------------------------------------------------------
// radial_dead_zone_rescale_top
// scaled radial dead zone for one stick vector per clock
// ----------------------------------------------------------------------------
// A new word is taken in every clock cycle and busy stays low. Each word
// passes through stages 0 to 2, the square root row (one cell per root bit),
// stage 3, the ramp divider row, stage 4, the x and y divider rows (one
// cell per quotient bit) and the output register. The result is shown for
// one cycle with o_strobe and must be taken then. The user must write the
// registers only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module radial_dead_zone_rescale_top import rdz_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SAMPLE_BITS-1:0]  i_x_in,
    input  logic [SAMPLE_BITS-1:0]  i_y_in,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [SAMPLE_BITS-2:0]  i_cfg_data,
    output logic                    o_strobe,
    output logic [SAMPLE_BITS-1:0]  o_x_out,
    output logic [SAMPLE_BITS-1:0]  o_y_out,
    output logic [1:0]              o_zone
);

    localparam int N   = SAMPLE_BITS;
    localparam int RB  = N - 1;
    localparam int W   = 2 * N + 1;
    localparam int PW1 = 2 * N + 4;
    localparam int PW2 = 3 * N + 4;
    localparam logic [RB-1:0] RST_LOWER = RB'(rdz_from_q15(Q15_LOWER, N));
    localparam logic [RB-1:0] RST_UPPER = RB'(rdz_from_q15(Q15_UPPER, N));
    localparam logic [RB-1:0] RST_VALUE = RB'(rdz_from_q15(Q15_VALUE, N));

    // configuration
    logic [RB-1:0] r_lower, r_upper, r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= RST_LOWER;
            r_upper <= RST_UPPER;
            r_value <= RST_VALUE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOWER: r_lower <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data;
                CFG_VALUE: r_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: magnitudes and signs
    logic         r0_v;
    logic [N-1:0] r0_ax, r0_ay;
    logic         r0_nx, r0_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_nx <= i_x_in[N-1];
        r0_ny <= i_y_in[N-1];
        r0_ax <= i_x_in[N-1] ? (~i_x_in + N'(1)) : i_x_in;
        r0_ay <= i_y_in[N-1] ? (~i_y_in + N'(1)) : i_y_in;
    end

    // stage 1: squares
    logic            r1_v;
    logic [W-1:0]    r1_m2;
    logic [2*RB-1:0] r1_ll, r1_uu;
    logic [N-1:0]    r1_ax, r1_ay;
    logic            r1_nx, r1_ny;
    logic [2*N-1:0]  s1_xx, s1_yy;

    assign s1_xx = r0_ax * r0_ax;
    assign s1_yy = r0_ay * r0_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_m2 <= W'(s1_xx) + W'(s1_yy);
        r1_ll <= r_lower * r_lower;
        r1_uu <= r_upper * r_upper;
        r1_ax <= r0_ax;
        r1_ay <= r0_ay;
        r1_nx <= r0_nx;
        r1_ny <= r0_ny;
    end

    // stage 2: zone
    logic         r2_v;
    logic [W-1:0] r2_m2;
    t_zone        r2_zone;
    logic [N-1:0] r2_ax, r2_ay;
    logic         r2_nx, r2_ny;
    t_zone        n2_zone;

    always_comb begin
        priority if (r1_m2 <= W'(r1_ll)) begin
            n2_zone = ZONE_DEAD;
        end else if (r1_m2 >= W'(r1_uu)) begin
            n2_zone = ZONE_SAT;
        end else begin
            n2_zone = ZONE_RAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_m2   <= r1_m2;
        r2_zone <= n2_zone;
        r2_ax   <= r1_ax;
        r2_ay   <= r1_ay;
        r2_nx   <= r1_nx;
        r2_ny   <= r1_ny;
    end

    // square root row
    logic           sq_v    [0:N];
    logic [W-1:0]   sq_rem  [0:N];
    logic [N-1:0]   sq_root [0:N];
    logic [PW1-1:0] sq_pass [0:N];

    assign sq_v[0]    = r2_v;
    assign sq_rem[0]  = r2_m2;
    assign sq_root[0] = '0;
    assign sq_pass[0] = {r2_ax, r2_ay, r2_nx, r2_ny, r2_zone};

    for (genvar i = 0; i < N; i++) begin : g_sqrt
        rdz_sqrt_cell #(.W(W), .RN(N), .K(N - 1 - i), .PW(PW1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[i]),
            .i_rem   (sq_rem[i]),
            .i_root  (sq_root[i]),
            .i_pass  (sq_pass[i]),
            .o_valid (sq_v[i+1]),
            .o_rem   (sq_rem[i+1]),
            .o_root  (sq_root[i+1]),
            .o_pass  (sq_pass[i+1])
        );
    end

    // stage 3: ramp numerator and divisor
    logic [N-1:0]   s3_ax, s3_ay;
    logic           s3_nx, s3_ny;
    t_zone          s3_zone;
    logic [N-1:0]   s3_diff;
    logic [RB-1:0]  s3_d;
    logic [2*N-1:0] s3_prod;

    assign {s3_ax, s3_ay, s3_nx, s3_ny, s3_zone} = sq_pass[N];
    assign s3_diff = sq_root[N] - N'(r_lower);
    assign s3_d    = r_upper - r_lower;
    assign s3_prod = r_value * s3_diff;

    logic           r3_v;
    logic [W-1:0]   r3_num, r3_den;
    logic [PW2-1:0] r3_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= sq_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_num  <= (W'(s3_prod) << 1) + W'(s3_d);
        r3_den  <= W'(s3_d) << 1;
        r3_pass <= {sq_root[N], s3_ax, s3_ay, s3_nx, s3_ny, s3_zone};
    end

    // ramp divider row
    logic           rd_v    [0:RB];
    logic [W-1:0]   rd_rem  [0:RB];
    logic [W-1:0]   rd_den  [0:RB];
    logic [RB-1:0]  rd_quo  [0:RB];
    logic [PW2-1:0] rd_pass [0:RB];

    assign rd_v[0]    = r3_v;
    assign rd_rem[0]  = r3_num;
    assign rd_den[0]  = r3_den;
    assign rd_quo[0]  = '0;
    assign rd_pass[0] = r3_pass;

    for (genvar i = 0; i < RB; i++) begin : g_ramp
        rdz_div_cell #(.W(W), .QB(RB), .K(RB - 1 - i), .PW(PW2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (rd_v[i]),
            .i_rem   (rd_rem[i]),
            .i_den   (rd_den[i]),
            .i_quo   (rd_quo[i]),
            .i_pass  (rd_pass[i]),
            .o_valid (rd_v[i+1]),
            .o_rem   (rd_rem[i+1]),
            .o_den   (rd_den[i+1]),
            .o_quo   (rd_quo[i+1]),
            .o_pass  (rd_pass[i+1])
        );
    end

    // stage 4: component numerators
    logic [N-1:0]   s4_root, s4_ax, s4_ay;
    logic           s4_nx, s4_ny;
    t_zone          s4_zone;
    logic [RB-1:0]  s4_s;
    logic [2*N-1:0] s4_px, s4_py;

    assign {s4_root, s4_ax, s4_ay, s4_nx, s4_ny, s4_zone} = rd_pass[RB];
    assign s4_s  = (s4_zone == ZONE_SAT) ? r_value : rd_quo[RB];
    assign s4_px = s4_ax * s4_s;
    assign s4_py = s4_ay * s4_s;

    logic         r4_v;
    logic [W-1:0] r4_numx, r4_numy, r4_den;
    logic [3:0]   r4_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= rd_v[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        r4_numx <= (W'(s4_px) << 1) + W'(s4_root);
        r4_numy <= (W'(s4_py) << 1) + W'(s4_root);
        r4_den  <= W'(s4_root) << 1;
        r4_pass <= {s4_nx, s4_ny, s4_zone};
    end

    // component divider rows
    logic          cx_v    [0:RB];
    logic [W-1:0]  cx_rem  [0:RB];
    logic [W-1:0]  cx_den  [0:RB];
    logic [RB-1:0] cx_quo  [0:RB];
    logic [2:0]    cx_pass [0:RB];
    logic          cy_v    [0:RB];
    logic [W-1:0]  cy_rem  [0:RB];
    logic [W-1:0]  cy_den  [0:RB];
    logic [RB-1:0] cy_quo  [0:RB];
    logic [0:0]    cy_pass [0:RB];

    assign cx_v[0]    = r4_v;
    assign cx_rem[0]  = r4_numx;
    assign cx_den[0]  = r4_den;
    assign cx_quo[0]  = '0;
    assign cx_pass[0] = {r4_pass[3], r4_pass[1:0]};
    assign cy_v[0]    = r4_v;
    assign cy_rem[0]  = r4_numy;
    assign cy_den[0]  = r4_den;
    assign cy_quo[0]  = '0;
    assign cy_pass[0] = r4_pass[2];

    for (genvar i = 0; i < RB; i++) begin : g_comp
        rdz_div_cell #(.W(W), .QB(RB), .K(RB - 1 - i), .PW(3)) u_cell_x (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cx_v[i]),
            .i_rem   (cx_rem[i]),
            .i_den   (cx_den[i]),
            .i_quo   (cx_quo[i]),
            .i_pass  (cx_pass[i]),
            .o_valid (cx_v[i+1]),
            .o_rem   (cx_rem[i+1]),
            .o_den   (cx_den[i+1]),
            .o_quo   (cx_quo[i+1]),
            .o_pass  (cx_pass[i+1])
        );
        rdz_div_cell #(.W(W), .QB(RB), .K(RB - 1 - i), .PW(1)) u_cell_y (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cy_v[i]),
            .i_rem   (cy_rem[i]),
            .i_den   (cy_den[i]),
            .i_quo   (cy_quo[i]),
            .i_pass  (cy_pass[i]),
            .o_valid (cy_v[i+1]),
            .o_rem   (cy_rem[i+1]),
            .o_den   (cy_den[i+1]),
            .o_quo   (cy_quo[i+1]),
            .o_pass  (cy_pass[i+1])
        );
    end

    // output word
    logic         s5_nx, s5_ny;
    t_zone        s5_zone;
    logic [N-1:0] s5_qx, s5_qy;

    assign {s5_nx, s5_zone} = cx_pass[RB];
    assign s5_ny = cy_pass[RB][0];
    assign s5_qx = N'(cx_quo[RB]);
    assign s5_qy = N'(cy_quo[RB]);

    logic         r_strobe;
    logic [N-1:0] r_x_out, r_y_out;
    logic [1:0]   r_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= cx_v[RB] & cy_v[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_zone <= s5_zone;
        if (s5_zone == ZONE_DEAD) begin
            r_x_out <= '0;
            r_y_out <= '0;
        end else begin
            r_x_out <= s5_nx ? (~s5_qx + N'(1)) : s5_qx;
            r_y_out <= s5_ny ? (~s5_qy + N'(1)) : s5_qy;
        end
    end

    assign o_strobe = r_strobe;
    assign o_x_out  = r_x_out;
    assign o_y_out  = r_y_out;
    assign o_zone   = r_zone;

endmodule

// ===== design/rdz_checker.sv =====
// ----------------------------------------------------------------------------
// rdz_checker
// port level checks of the radial dead zone rescaler
// ----------------------------------------------------------------------------
module rdz_checker import rdz_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_strobe,
    input logic [SAMPLE_BITS-1:0] o_x_out,
    input logic [SAMPLE_BITS-1:0] o_y_out,
    input logic [1:0]             o_zone
);

    localparam int LAT = rdz_latency(SAMPLE_BITS);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_word_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("word without start");

    a_start_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe)
        else $error("start lost");

    a_zone_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_zone != ZONE_BAD)
        else $error("bad zone code");

    a_dead_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_zone == ZONE_DEAD |-> o_x_out == '0 && o_y_out == '0)
        else $error("dead zone word not zero");

endmodule

bind radial_dead_zone_rescale_top rdz_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rdz_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_x_out  (o_x_out),
    .o_y_out  (o_y_out),
    .o_zone   (o_zone)
);
